@@ hw/rtl/fgam_pkg.sv @@
package fgam_pkg;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_OPEN    = 2'd1,
    OP_SAMPLE  = 2'd2,
    OP_CLOSE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_L,
    ST_ADD_R,
    ST_DRAIN,
    ST_SEND,
    ST_FRAME,
    ST_CLOSE,
    ST_STATUS
  } state_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned SpaceW  = 6;

  // one request to the shared accumulate unit
  typedef struct packed {
    logic add;
    logic sel_right;
    logic clear;
  } acc_ctrl_t;

endpackage

@@ hw/rtl/frame_gated_audio_mixer_fifo.sv @@
// Frame-gated stereo mixer with an output ring buffer.
// Command channel: an item (op, channel, samples, sink space) transfers at a
// rising edge with start_i high and busy_o low; busy_o stays high until the
// item has finished, and no new item is taken meanwhile.
// Result channel: every result is shown for one cycle with out_valid_o high;
// the receiver cannot stall it. Each item ends with a status result (last_o),
// which may follow zero or more sink samples (is_status_o low).
// Each drained sample passes a ring read state (ST_DRAIN) and a send state
// (ST_SEND) through the registered read port; both sums share one 32-bit
// accumulate adder, so the left addition and the right addition run in turn.
// Reset clears the ring pointers, prefill flag, channel masks and sums. The
// ring contents are not cleared; only entries already written are read.
module frame_gated_audio_mixer_fifo #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned CHANNELS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        op_i,
  input  logic [3:0]                        channel_i,
  input  logic signed [fgam_pkg::SampleW-1:0] left_in_i,
  input  logic signed [fgam_pkg::SampleW-1:0] right_in_i,
  input  logic [fgam_pkg::SpaceW-1:0]       sink_space_i,
  output logic                              out_valid_o,
  output logic                              is_status_o,
  output logic signed [fgam_pkg::SampleW-1:0] left_out_o,
  output logic signed [fgam_pkg::SampleW-1:0] right_out_o,
  output logic                              accepted_o,
  output logic                              stop_sink_o,
  output logic                              last_o
);
  import fgam_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned EntW = 2 * SampleW;

  state_e state_q, state_d;

  op_e                 op_q, op_d;
  logic [3:0]          chan_q, chan_d;
  logic signed [SampleW-1:0] lin_q, lin_d, rin_q, rin_d;
  logic [SpaceW-1:0]   space_q, space_d;
  logic                acc_q, acc_d, stop_q, stop_d;
  logic [IdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic                prefilled_q, prefilled_d;
  logic [CHANNELS-1:0] open_q, open_d, contrib_q, contrib_d;

  logic [CHANNELS-1:0] ch_bit, open_after_close;
  logic                frame_done, close_stop;
  logic [IdxW-1:0]     wr_next, rd_next;

  acc_ctrl_t           acc_ctrl;
  logic [SumW-1:0]     left_sum, right_sum;

  logic                ram_we, ram_re;
  logic [EntW-1:0]     ram_rdata;

  fgam_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .left_i     (lin_q),
    .right_i    (rin_q),
    .left_sum_o (left_sum),
    .right_sum_o(right_sum)
  );

  fgam_ram #(
    .Width(EntW),
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_q),
    .wdata_i({left_sum[SampleW-1:0], right_sum[SampleW-1:0]}),
    .re_i   (ram_re),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  // shifting past the mask width leaves no bit set for channels out of range
  assign ch_bit           = {{(CHANNELS-1){1'b0}}, 1'b1} << chan_q;
  assign frame_done       = (open_q & ~contrib_q) == '0;
  assign open_after_close = open_q & ~ch_bit;
  assign close_stop       = open_after_close == '0;
  assign wr_next = (wr_q == IdxW'(RING_DEPTH - 1)) ? '0 : wr_q + IdxW'(1);
  assign rd_next = (rd_q == IdxW'(RING_DEPTH - 1)) ? '0 : rd_q + IdxW'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    chan_d      = chan_q;
    lin_d       = lin_q;
    rin_d       = rin_q;
    space_d     = space_q;
    acc_d       = acc_q;
    stop_d      = stop_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    prefilled_d = prefilled_q;
    open_d      = open_q;
    contrib_d   = contrib_q;
    acc_ctrl    = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = op_e'(op_i);
          chan_d  = channel_i;
          space_d = sink_space_i;
          acc_d   = 1'b0;
          stop_d  = 1'b0;
          // a close feeds the channel a zero sample
          lin_d   = (op_e'(op_i) == OP_CLOSE) ? '0 : left_in_i;
          rin_d   = (op_e'(op_i) == OP_CLOSE) ? '0 : right_in_i;
          state_d = ST_STATUS;
          if (op_e'(op_i) == OP_RESTART) begin
            prefilled_d = 1'b0;
          end else if ({1'b0, channel_i} < 5'(CHANNELS)) begin
            if (op_e'(op_i) == OP_OPEN) begin
              state_d = ST_STATUS;
              open_d    = open_q | ({{(CHANNELS-1){1'b0}}, 1'b1} << channel_i);
              contrib_d = contrib_q & ~({{(CHANNELS-1){1'b0}}, 1'b1} << channel_i);
            end else begin
              state_d = ST_ADD_L;
            end
          end
        end
      end
      ST_ADD_L: begin
        if ((contrib_q & ch_bit) == '0) begin
          acc_ctrl.add = 1'b1;
          acc_d        = 1'b1;
        end
        state_d = ST_ADD_R;
      end
      ST_ADD_R: begin
        if (acc_q) begin
          acc_ctrl.add       = 1'b1;
          acc_ctrl.sel_right = 1'b1;
          contrib_d          = contrib_q | ch_bit;
        end
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (prefilled_q && (rd_q != wr_q) && (space_q != '0)) begin
          ram_re  = 1'b1;
          state_d = ST_SEND;
        end else begin
          state_d = ST_FRAME;
        end
      end
      ST_SEND: begin
        rd_d    = rd_next;
        space_d = space_q - SpaceW'(1);
        state_d = ST_DRAIN;
      end
      ST_FRAME: begin
        if (frame_done) begin
          if (wr_next == rd_q) begin
            prefilled_d = 1'b1;
          end else begin
            ram_we         = 1'b1;
            wr_d           = wr_next;
            contrib_d      = '0;
            acc_ctrl.clear = 1'b1;
          end
        end
        state_d = (op_q == OP_CLOSE) ? ST_CLOSE : ST_STATUS;
      end
      ST_CLOSE: begin
        contrib_d = contrib_q & ~ch_bit;
        open_d    = open_after_close;
        stop_d    = close_stop;
        state_d   = ST_STATUS;
      end
      ST_STATUS: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      prefilled_q <= 1'b0;
      open_q      <= '0;
      contrib_q   <= '0;
      acc_q       <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      prefilled_q <= prefilled_d;
      open_q      <= open_d;
      contrib_q   <= contrib_d;
      acc_q       <= acc_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    chan_q  <= chan_d;
    lin_q   <= lin_d;
    rin_q   <= rin_d;
    space_q <= space_d;
  end

  logic close_send;
  assign close_send = (state_q == ST_CLOSE) && close_stop && (space_q != '0);

  assign busy_o      = state_q != ST_IDLE;
  assign out_valid_o = (state_q == ST_SEND) || close_send || (state_q == ST_STATUS);
  assign is_status_o = state_q == ST_STATUS;
  assign left_out_o  = (state_q == ST_SEND) ? ram_rdata[EntW-1:SampleW] : '0;
  assign right_out_o = (state_q == ST_SEND) ? ram_rdata[SampleW-1:0] : '0;
  assign accepted_o  = (state_q == ST_STATUS) && acc_q;
  assign stop_sink_o = (state_q == ST_STATUS) && stop_q;
  assign last_o      = state_q == ST_STATUS;

`ifndef SYNTHESIS
  a_result_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result outside an item");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer did not raise busy");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !busy_o)
    else $error("item continues after its status");

  a_ring_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring read and write in one cycle");

  a_sample_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_status_o) |-> (!accepted_o && !stop_sink_o && !last_o))
    else $error("status flags on a sink sample");
`endif

endmodule

@@ hw/rtl/fgam_ram.sv @@
module fgam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fgam_acc.sv @@
module fgam_acc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fgam_pkg::acc_ctrl_t               ctrl_i,
  input  logic signed [fgam_pkg::SampleW-1:0] left_i,
  input  logic signed [fgam_pkg::SampleW-1:0] right_i,
  output logic [fgam_pkg::SumW-1:0]         left_sum_o,
  output logic [fgam_pkg::SumW-1:0]         right_sum_o
);
  import fgam_pkg::*;

  logic [SumW-1:0] left_q, left_d, right_q, right_d;
  logic signed [SampleW-1:0] operand;
  logic signed [SampleW:0]   widened, adjusted, quot;
  logic [SumW-1:0]           addend, sum_sel, result;

  // sample / 4 rounded toward zero: bias negatives by 3 before the shift
  always_comb begin
    operand  = ctrl_i.sel_right ? right_i : left_i;
    widened  = {operand[SampleW-1], operand};
    adjusted = widened + (operand[SampleW-1] ? (SampleW+1)'(3) : '0);
    quot     = adjusted >>> 2;
    addend   = {{(SumW-SampleW-1){quot[SampleW]}}, quot};
    sum_sel  = ctrl_i.sel_right ? right_q : left_q;
    result   = sum_sel + addend;
  end

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (ctrl_i.clear) begin
      left_d  = '0;
      right_d = '0;
    end else if (ctrl_i.add) begin
      if (ctrl_i.sel_right) begin
        right_d = result;
      end else begin
        left_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_sum_o  = left_q;
  assign right_sum_o = right_q;

endmodule

@@ verif/frame_gated_audio_mixer_fifo_tb.sv @@
module frame_gated_audio_mixer_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fgam_pkg::*;

  localparam int unsigned RING_DEPTH     = 32;
  localparam int unsigned CHANNELS       = 16;
  localparam int unsigned ITEM_TARGET    = 330;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned IDLE_PERCENT   = 24;
  localparam int unsigned CALM_FIRST     = 150;
  localparam int unsigned CALM_END       = 230;

  typedef struct {
    op_e                      op;
    logic [3:0]               ch;
    logic signed [SampleW-1:0] l;
    logic signed [SampleW-1:0] r;
    logic [SpaceW-1:0]        space;
    bit                       hold;
  } mix_cmd_t;

  typedef struct {
    logic                      is_status;
    logic signed [SampleW-1:0] l;
    logic signed [SampleW-1:0] r;
    logic                      acc;
    logic                      stop;
    logic                      last;
  } sink_word_t;

  logic clk_i;
  logic rst_ni;
  logic cmd_start;
  logic busy_o;
  logic out_valid_o;
  logic is_status_o;
  logic signed [SampleW-1:0] left_out_o;
  logic signed [SampleW-1:0] right_out_o;
  logic accepted_o;
  logic stop_sink_o;
  logic last_o;

  mix_cmd_t   cur_cmd;
  mix_cmd_t   cmd_q[$];
  sink_word_t sink_words_q[$];
  logic       cmd_fire;
  int unsigned issued;
  int unsigned stall_cycles;
  int unsigned mismatches;
  bit          idle_now;
  bit          fire_now;
  sink_word_t  got;
  sink_word_t  want;

  // mixer shadow
  logic [SampleW-1:0] ring_l[RING_DEPTH];
  logic [SampleW-1:0] ring_r[RING_DEPTH];
  int unsigned        wr_pos;
  int unsigned        rd_pos;
  logic               prefill;
  logic [CHANNELS-1:0] open_m;
  logic [CHANNELS-1:0] contrib_m;
  logic [SumW-1:0]    sum_l;
  logic [SumW-1:0]    sum_r;

  // stimulus bookkeeping
  logic [15:0] gen_open;
  logic [15:0] gen_contrib;
  bit          hold_next;

  frame_gated_audio_mixer_fifo #(
    .RING_DEPTH(RING_DEPTH),
    .CHANNELS  (CHANNELS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_start),
    .busy_o      (busy_o),
    .op_i        (cur_cmd.op),
    .channel_i   (cur_cmd.ch),
    .left_in_i   (cur_cmd.l),
    .right_in_i  (cur_cmd.r),
    .sink_space_i(cur_cmd.space),
    .out_valid_o (out_valid_o),
    .is_status_o (is_status_o),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .accepted_o  (accepted_o),
    .stop_sink_o (stop_sink_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sink_word_t sink_sample(logic [SampleW-1:0] l, logic [SampleW-1:0] r);
    sink_word_t w;
    w = '{1'b0, l, r, 1'b0, 1'b0, 1'b0};
    return w;
  endfunction

  // add one channel sample, drain while prefilled, then try to close the frame
  task automatic mix_in(input logic [3:0] ch, input logic signed [SampleW-1:0] l,
                        input logic signed [SampleW-1:0] r, inout int unsigned room,
                        output logic acc);
    int          sl;
    int          sr;
    int unsigned nxt;
    sl = int'(l);
    sr = int'(r);
    acc = 1'b0;
    if (!contrib_m[ch]) begin
      sum_l = sum_l + SumW'(sl / 4);
      sum_r = sum_r + SumW'(sr / 4);
      contrib_m[ch] = 1'b1;
      acc = 1'b1;
    end
    if (prefill) begin
      while (rd_pos != wr_pos && room > 0) begin
        sink_words_q.push_back(sink_sample(ring_l[rd_pos], ring_r[rd_pos]));
        rd_pos = (rd_pos + 1) % RING_DEPTH;
        room--;
      end
    end
    if ((open_m & ~contrib_m) == '0) begin
      nxt = (wr_pos + 1) % RING_DEPTH;
      if (nxt == rd_pos) begin
        prefill = 1'b1;
      end else begin
        ring_l[wr_pos] = sum_l[SampleW-1:0];
        ring_r[wr_pos] = sum_r[SampleW-1:0];
        wr_pos = nxt;
        contrib_m = '0;
        sum_l = '0;
        sum_r = '0;
      end
    end
  endtask

  task automatic mixer_step(input mix_cmd_t c);
    int unsigned room;
    logic        acc;
    logic        stop;
    sink_word_t  w;
    room = c.space;
    acc = 1'b0;
    stop = 1'b0;
    case (c.op)
      OP_RESTART: prefill = 1'b0;
      OP_OPEN: begin
        open_m[c.ch] = 1'b1;
        contrib_m[c.ch] = 1'b0;
      end
      OP_SAMPLE: mix_in(c.ch, c.l, c.r, room, acc);
      OP_CLOSE: begin
        mix_in(c.ch, '0, '0, room, acc);
        contrib_m[c.ch] = 1'b0;
        open_m[c.ch] = 1'b0;
        if (open_m == '0) begin
          stop = 1'b1;
          if (room > 0) begin
            sink_words_q.push_back(sink_sample('0, '0));
            room--;
          end
        end
      end
      default: ;
    endcase
    w = '{1'b1, '0, '0, acc, stop, 1'b1};
    sink_words_q.push_back(w);
  endtask

  task automatic flag_mismatch(input string what, input sink_word_t exp_w,
                               input sink_word_t got_w);
    if (mismatches < 10)
      $display("[%0t] %s: expected st=%0b l=%0d r=%0d acc=%0b stop=%0b last=%0b, got st=%0b l=%0d r=%0d acc=%0b stop=%0b last=%0b",
               $realtime, what, exp_w.is_status, exp_w.l, exp_w.r, exp_w.acc, exp_w.stop,
               exp_w.last, got_w.is_status, got_w.l, got_w.r, got_w.acc, got_w.stop,
               got_w.last);
    mismatches++;
  endtask

  // stimulus helpers
  task automatic add_cmd(input op_e op, input logic [3:0] ch,
                         input logic signed [SampleW-1:0] l,
                         input logic signed [SampleW-1:0] r, input logic [SpaceW-1:0] space);
    mix_cmd_t c;
    c = '{op, ch, l, r, space, hold_next};
    hold_next = 1'b0;
    cmd_q.push_back(c);
    case (op)
      OP_OPEN: begin
        gen_open[ch] = 1'b1;
        gen_contrib[ch] = 1'b0;
      end
      OP_SAMPLE: begin
        gen_contrib[ch] = 1'b1;
        if ((gen_open & ~gen_contrib) == '0) gen_contrib = '0;
      end
      OP_CLOSE: begin
        gen_open[ch] = 1'b0;
        gen_contrib[ch] = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [3:0] pick_from(logic [15:0] mask);
    logic [3:0] ch;
    ch = 4'($urandom_range(0, 15));
    while (!mask[ch]) ch = ch + 1'b1;
    return ch;
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 7)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SpaceW-1:0] rand_space();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return 6'd32;
    if (r == 4) return 6'd31;
    return 6'($urandom_range(1, 6));
  endfunction

  // close everything, push frames with no sink room until the ring is full, then one with room to drain it
  task automatic fill_ring();
    int unsigned k;
    while (gen_open != '0) add_cmd(OP_CLOSE, pick_from(gen_open), '0, '0, rand_space());
    for (k = 0; k < 33; k++)
      add_cmd(OP_SAMPLE, 4'($urandom), rand_sample(), rand_sample(), '0);
    add_cmd(OP_SAMPLE, 4'($urandom), rand_sample(), rand_sample(), 6'd32);
  endtask

  task automatic random_cmd();
    int unsigned r;
    logic [15:0] pending;
    r = $urandom_range(0, 99);
    pending = gen_open & ~gen_contrib;
    if (r < 4) begin
      add_cmd(OP_RESTART, 4'($urandom), 16'($urandom), 16'($urandom), rand_space());
    end else if (r < 12) begin
      add_cmd(OP_OPEN, 4'($urandom), 16'($urandom), 16'($urandom), rand_space());
    end else if (r < 19) begin
      if (gen_open != '0 && $urandom_range(0, 4) != 0)
        add_cmd(OP_CLOSE, pick_from(gen_open), 16'($urandom), 16'($urandom), rand_space());
      else
        add_cmd(OP_CLOSE, 4'($urandom), 16'($urandom), 16'($urandom), rand_space());
    end else if (pending != '0 && $urandom_range(0, 99) < 85) begin
      add_cmd(OP_SAMPLE, pick_from(pending), rand_sample(), rand_sample(), rand_space());
    end else begin
      add_cmd(OP_SAMPLE, 4'($urandom), rand_sample(), rand_sample(), rand_space());
    end
  endtask

  // driver: one item at a time, new values at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!cmd_start || cmd_fire)) begin
      idle_now = !(issued >= CALM_FIRST && issued < CALM_END) &&
                 ($urandom_range(0, 99) < IDLE_PERCENT);
      if (cmd_q.size() != 0 && !idle_now &&
          !(cmd_q[0].hold && sink_words_q.size() != 0)) begin
        cur_cmd <= cmd_q.pop_front();
        cmd_start <= 1'b1;
        issued++;
      end else begin
        cmd_start <= 1'b0;
      end
    end
  end

  // monitor, predictor hook and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      fire_now = cmd_start && !busy_o;
      if (out_valid_o) begin
        got = '{is_status_o, left_out_o, right_out_o, accepted_o, stop_sink_o, last_o};
        if (sink_words_q.size() == 0) begin
          want = '{1'bx, 'x, 'x, 1'bx, 1'bx, 1'bx};
          flag_mismatch("unexpected result", want, got);
        end else begin
          want = sink_words_q.pop_front();
          if (got.is_status !== want.is_status || got.l !== want.l || got.r !== want.r ||
              got.acc !== want.acc || got.stop !== want.stop || got.last !== want.last)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (fire_now) mixer_step(cur_cmd);
      cmd_fire <= fire_now;
      if (fire_now || out_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cmd_start = 1'b0;
    cmd_fire = 1'b0;
    cur_cmd = '{OP_RESTART, '0, '0, '0, '0, 1'b0};
    issued = 0;
    stall_cycles = 0;
    mismatches = 0;
    wr_pos = 0;
    rd_pos = 0;
    prefill = 1'b0;
    open_m = '0;
    contrib_m = '0;
    sum_l = '0;
    sum_r = '0;
    gen_open = '0;
    gen_contrib = '0;
    hold_next = 1'b0;

    // directed: truncation, repeats, closed channels, last-close with and without room
    add_cmd(OP_SAMPLE, 4'd0, 16'sh7fff, 16'sh8000, 6'd0);
    add_cmd(OP_SAMPLE, 4'd15, -16'sd3, 16'sd3, 6'd32);
    add_cmd(OP_OPEN, 4'd0, 16'sh5555, 16'shaaaa, 6'd31);
    add_cmd(OP_OPEN, 4'd15, 16'shaaaa, 16'sh5555, 6'd0);
    add_cmd(OP_SAMPLE, 4'd0, -16'sd1, -16'sd5, 6'd1);
    add_cmd(OP_SAMPLE, 4'd0, 16'sd100, 16'sd200, 6'd2);
    add_cmd(OP_SAMPLE, 4'd10, 16'sh5555, 16'shaaaa, 6'd32);
    add_cmd(OP_SAMPLE, 4'd15, 16'shaaaa, 16'sh5555, 6'd31);
    add_cmd(OP_RESTART, 4'd5, 16'sh7fff, 16'sh8000, 6'd32);
    add_cmd(OP_OPEN, 4'd5, 16'sd0, 16'sd0, 6'd0);
    add_cmd(OP_SAMPLE, 4'd5, 16'sh8000, 16'sh7fff, 6'd4);
    add_cmd(OP_CLOSE, 4'd0, 16'sh7fff, 16'sh7fff, 6'd1);
    add_cmd(OP_CLOSE, 4'd5, 16'sd0, 16'sd0, 6'd3);
    add_cmd(OP_CLOSE, 4'd15, 16'sh8000, 16'sh8000, 6'd0);
    add_cmd(OP_OPEN, 4'd3, 16'sd0, 16'sd0, 6'd0);
    add_cmd(OP_CLOSE, 4'd3, 16'sd0, 16'sd0, 6'd5);
    add_cmd(OP_CLOSE, 4'd3, 16'sd0, 16'sd0, 6'd2);
    add_cmd(OP_SAMPLE, 4'd7, 16'sh8000, 16'sh8000, 6'd31);
    add_cmd(OP_SAMPLE, 4'd7, 16'sh7fff, 16'sh7fff, 6'd0);

    hold_next = 1'b1;
    while (cmd_q.size() < ITEM_TARGET) begin
      if (cmd_q.size() == 40 || cmd_q.size() == 210) fill_ring();
      else begin
        if (cmd_q.size() == 120) hold_next = 1'b1;
        random_cmd();
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (cmd_q.size() == 0);
    @(negedge clk_i);
    while (cmd_start) @(negedge clk_i);
    while (sink_words_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && sink_words_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
